[hw/rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion macros shared by the rtl; define ASSERT_OFF to drop them
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// property that must hold at every clock edge outside reset
`define ASSERT_RST(name, clk, rst_n, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// non-overlapping implication from trigger to consequence, outside reset
`define ASSERT_NEXT(name, clk, rst_n, trig, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cons)) else $error(msg);

`else

`define ASSERT_RST(name, clk, rst_n, prop, msg)
`define ASSERT_NEXT(name, clk, rst_n, trig, cons, msg)

`endif

`endif

[hw/rtl/bcdist_pkg.sv]
// ----------------------------------------------------------------------------
// bcdist_pkg
// Shared types and constants of the burst-fire cycle distributor
// ----------------------------------------------------------------------------
`default_nettype none

package bcdist_pkg;

  // mains cycles in one distribution period
  localparam logic [3:0] PERIOD = 4'd10;

  // field and state widths
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned ACCUM_W = 7;
  localparam int unsigned SHARE_W = 4;
  localparam int unsigned ERR_W   = 6;
  localparam int unsigned COUNT_W = 4;

  // full scale of the percentage
  localparam int unsigned PCT_FULL = 100;

  // ascii codes seen by the parser
  localparam logic [BYTE_W-1:0] CHAR_NEWLINE = 8'h0A;
  localparam logic [BYTE_W-1:0] CHAR_ZERO    = 8'h30;
  localparam logic [BYTE_W-1:0] CHAR_NINE    = 8'h39;

  // kind of input word
  typedef enum logic {
    OP_BYTE = 1'b0,
    OP_TICK = 1'b1
  } op_e;

endpackage

`default_nettype wire

[hw/rtl/bcdist_in_if.sv]
// ----------------------------------------------------------------------------
// bcdist_in_if
// Input channel: serial bytes and zero-cross ticks with valid/ready
// ----------------------------------------------------------------------------
`default_nettype none

interface bcdist_in_if import bcdist_pkg::*; ();

  logic              valid;
  logic              ready;
  op_e               operation;
  logic [BYTE_W-1:0] byte_value;

  modport source (output valid, output operation, output byte_value, input ready);
  modport sink   (input valid, input operation, input byte_value, output ready);

endinterface

`default_nettype wire

[hw/rtl/bcdist_out_if.sv]
// ----------------------------------------------------------------------------
// bcdist_out_if
// Output channel: gate bits for one mains cycle with valid/ready
// ----------------------------------------------------------------------------
`default_nettype none

interface bcdist_out_if;

  logic valid;
  logic ready;
  logic gate_a;
  logic gate_b;

  modport source (output valid, output gate_a, output gate_b, input ready);
  modport sink   (input valid, input gate_a, input gate_b, output ready);

endinterface

`default_nettype wire

[hw/rtl/bresenham_cycle_distributor.sv]
// ----------------------------------------------------------------------------
// bresenham_cycle_distributor
// Burst-fire distribution of mains cycles between two channels
//
// in_i carries one word per serial byte or per zero-cross tick. Bytes build a
// decimal percentage (saturated at 100); a newline splits the period of
// PERIOD mains cycles into share A = floor(percent*PERIOD/100) and share B.
// Each tick word yields one word on out_o with the two gate bits for that
// mains cycle, chosen by a Bresenham error term per channel. Bytes yield none.
// A tick's gate word is registered and shows up on out_o in the cycle after
// the tick is accepted. Throughput: one input word per cycle unless out_o stalls;
// all state updates are combinational, feeding the state and output registers.
// in_i.ready stays high while the output register is empty or being drained,
// so a new word enters in the same cycle that the old result leaves. When
// the receiver stalls with a result pending, ready drops and input waits.
// Reset clears the percentage, the shares, the error terms and the period
// counter and empties the output register; until the first newline both
// shares are zero.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module bresenham_cycle_distributor import bcdist_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  bcdist_in_if.sink    in_i,
  bcdist_out_if.source out_o
);

  localparam int unsigned PROD_W  = ACCUM_W + SHARE_W;
  localparam int unsigned VALUE_W = ACCUM_W + 3;
  localparam logic signed [ERR_W-1:0] ERR_MAX = ERR_W'(2 * int'(PERIOD));
  localparam logic signed [ERR_W-1:0] ERR_MIN = -ERR_MAX;

  // initial error term 2*share - PERIOD
  function automatic logic signed [ERR_W-1:0] init_err(input logic [SHARE_W-1:0] share);
    init_err = $signed({1'b0, share, 1'b0}) - $signed({1'b0, PERIOD, 1'b0}) / 2;
  endfunction

  // error step when the channel fires: 2*(share - PERIOD)
  function automatic logic signed [ERR_W-1:0] fire_step(input logic [SHARE_W-1:0] share);
    fire_step = $signed({1'b0, share, 1'b0}) - $signed({1'b0, PERIOD, 1'b0});
  endfunction

  // error step when the channel idles: 2*share
  function automatic logic signed [ERR_W-1:0] idle_step(input logic [SHARE_W-1:0] share);
    idle_step = $signed({1'b0, share, 1'b0});
  endfunction

  logic [ACCUM_W-1:0]        accum_q, accum_d;
  logic                      stopped_q, stopped_d;
  logic [SHARE_W-1:0]        share_a_q, share_a_d;
  logic [SHARE_W-1:0]        share_b_q, share_b_d;
  logic signed [ERR_W-1:0]   err_a_q, err_a_d;
  logic signed [ERR_W-1:0]   err_b_q, err_b_d;
  logic [COUNT_W-1:0]        tick_q, tick_d;
  logic                      out_valid_q, out_valid_d;
  logic                      gate_a_q, gate_a_d;
  logic                      gate_b_q, gate_b_d;

  logic                      in_fire;
  logic [PROD_W-1:0]         prod;
  logic [SHARE_W-1:0]        share_new;
  logic [SHARE_W-1:0]        share_b_new;
  logic [VALUE_W-1:0]        digit_value;
  logic                      reload;
  logic signed [ERR_W-1:0]   base_a, base_b;
  logic                      fire_a, fire_b;

  // handshake: take a word whenever the output register is free or drains
  assign in_i.ready = !out_valid_q || out_o.ready;
  assign in_fire    = in_i.valid && in_i.ready;

  // share of channel A: largest k with percent*PERIOD >= 100*k
  assign prod = PROD_W'(accum_q) * PROD_W'(PERIOD);

  always_comb begin
    share_new = '0;
    for (int k = 1; k <= int'(PERIOD); k++) begin
      if (prod >= PROD_W'(PCT_FULL * k)) begin
        share_new = SHARE_W'(k);
      end
    end
  end

  assign share_b_new = PERIOD - share_new;

  // next decimal value from an incoming digit
  assign digit_value = VALUE_W'(accum_q) * VALUE_W'(10) + VALUE_W'(in_i.byte_value[3:0]);

  // bresenham step for both channels, reloading at the period wrap
  assign reload = (tick_q >= PERIOD);
  assign base_a = reload ? init_err(share_a_q) : err_a_q;
  assign base_b = reload ? init_err(share_b_q) : err_b_q;
  assign fire_a = !base_a[ERR_W-1];
  assign fire_b = !base_b[ERR_W-1];

  // state update for one accepted word
  always_comb begin
    accum_d   = accum_q;
    stopped_d = stopped_q;
    share_a_d = share_a_q;
    share_b_d = share_b_q;
    err_a_d   = err_a_q;
    err_b_d   = err_b_q;
    tick_d    = tick_q;
    if (in_fire) begin
      if (in_i.operation == OP_TICK) begin
        tick_d  = reload ? '0 : tick_q + COUNT_W'(1);
        err_a_d = base_a + (fire_a ? fire_step(share_a_q) : idle_step(share_a_q));
        err_b_d = base_b + (fire_b ? fire_step(share_b_q) : idle_step(share_b_q));
      end else if (in_i.byte_value == CHAR_NEWLINE) begin
        share_a_d = share_new;
        share_b_d = share_b_new;
        err_a_d   = init_err(share_new);
        err_b_d   = init_err(share_b_new);
        tick_d    = PERIOD;
        accum_d   = '0;
        stopped_d = 1'b0;
      end else if (in_i.byte_value inside {[CHAR_ZERO:CHAR_NINE]}) begin
        if (!stopped_q) begin
          accum_d = (digit_value > VALUE_W'(PCT_FULL)) ? ACCUM_W'(PCT_FULL)
                                                       : digit_value[ACCUM_W-1:0];
        end
      end else begin
        stopped_d = 1'b1;
      end
    end
  end

  // output register: load on a tick, empty when the word is taken
  always_comb begin
    out_valid_d = out_valid_q;
    gate_a_d    = gate_a_q;
    gate_b_d    = gate_b_q;
    if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
    if (in_fire && in_i.operation == OP_TICK) begin
      out_valid_d = 1'b1;
      gate_a_d    = fire_a;
      gate_b_d    = fire_b;
    end
  end

  // control and state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      accum_q     <= '0;
      stopped_q   <= 1'b0;
      share_a_q   <= '0;
      share_b_q   <= '0;
      err_a_q     <= '0;
      err_b_q     <= '0;
      tick_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      accum_q     <= accum_d;
      stopped_q   <= stopped_d;
      share_a_q   <= share_a_d;
      share_b_q   <= share_b_d;
      err_a_q     <= err_a_d;
      err_b_q     <= err_b_d;
      tick_q      <= tick_d;
      out_valid_q <= out_valid_d;
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    gate_a_q <= gate_a_d;
    gate_b_q <= gate_b_d;
  end

  assign out_o.valid  = out_valid_q;
  assign out_o.gate_a = gate_a_q;
  assign out_o.gate_b = gate_b_q;

  // checks on the distributor state
  `ASSERT_RST(a_tick_range, clk_i, rst_ni, tick_q <= PERIOD, "period counter past PERIOD")
  `ASSERT_RST(a_accum_range, clk_i, rst_ni, accum_q <= ACCUM_W'(PCT_FULL), "percentage over 100")
  `ASSERT_RST(a_share_sum, clk_i, rst_ni, (5'(share_a_q) + 5'(share_b_q) == 5'(PERIOD)) || (share_a_q == '0 && share_b_q == '0), "shares do not split the period")
  `ASSERT_RST(a_err_range, clk_i, rst_ni, err_a_q >= ERR_MIN && err_a_q <= ERR_MAX && err_b_q >= ERR_MIN && err_b_q <= ERR_MAX, "error term out of range")
  `ASSERT_NEXT(a_tick_result, clk_i, rst_ni, in_fire && in_i.operation == OP_TICK, out_valid_q, "tick gave no result")

endmodule

`default_nettype wire

[tb/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the burst-fire cycle distributor. Serial bytes
// (percent strings, noise, broken strings) and zero-cross ticks go in; an
// in-bench Bresenham predictor tracks the percentage, shares, error terms and
// period position and compares every gate word that comes out, in order.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;
  import bcdist_pkg::*;

  // one input word and one result word
  typedef struct packed {
    op_e               operation;
    logic [BYTE_W-1:0] byte_value;
  } serial_word_t;

  typedef struct packed {
    logic gate_a;
    logic gate_b;
  } gate_word_t;

  logic clk_i;
  logic rst_ni;

  bcdist_in_if  in_if ();
  bcdist_out_if out_if ();

  bresenham_cycle_distributor dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  // words waiting to be sent and gate words still owed by the block
  serial_word_t pending_words[$];
  gate_word_t   owed_gates[$];

  // predictor state
  logic [ACCUM_W-1:0]      pct_accum;
  logic                    pct_stopped;
  logic [SHARE_W-1:0]      share_a;
  logic [SHARE_W-1:0]      share_b;
  logic signed [ERR_W-1:0] err_a;
  logic signed [ERR_W-1:0] err_b;
  logic [COUNT_W-1:0]      mains_pos;

  int unsigned fail_count;
  int unsigned gates_seen;
  logic        in_taken;
  logic        out_taken;
  logic        hold_off;
  int unsigned send_wait;
  int unsigned recv_wait;
  logic        send_calm;
  logic        recv_calm;

  // clock
  always begin
    clk_i = 1'b0;
    #4;
    clk_i = 1'b1;
    #4;
  end

  // Bresenham start value of an error term
  function automatic logic signed [ERR_W-1:0] start_error(input logic [SHARE_W-1:0] s);
    int e;
    e = 2 * int'(s) - int'(PERIOD);
    return e[ERR_W-1:0];
  endfunction

  // fire when non-negative, then move the error term on
  task automatic advance_gate(inout logic signed [ERR_W-1:0] err,
                              input logic [SHARE_W-1:0] s, output logic fire);
    int e;
    e = err;
    fire = !err[ERR_W-1];
    e += fire ? 2 * (int'(s) - int'(PERIOD)) : 2 * int'(s);
    err = e[ERR_W-1:0];
  endtask

  // update the predicted state for one accepted word, queue the gate word
  task automatic predict_word(input serial_word_t w);
    int         v;
    gate_word_t g;
    if (w.operation == OP_BYTE) begin
      if (w.byte_value == CHAR_NEWLINE) begin
        v           = (int'(pct_accum) * int'(PERIOD)) / int'(PCT_FULL);
        share_a     = v[SHARE_W-1:0];
        share_b     = PERIOD - share_a;
        err_a       = start_error(share_a);
        err_b       = start_error(share_b);
        mains_pos   = PERIOD;
        pct_accum   = '0;
        pct_stopped = 1'b0;
      end else if (w.byte_value >= CHAR_ZERO && w.byte_value <= CHAR_NINE) begin
        if (!pct_stopped) begin
          v         = int'(pct_accum) * 10 + int'(w.byte_value - CHAR_ZERO);
          pct_accum = (v > int'(PCT_FULL)) ? PCT_FULL[ACCUM_W-1:0] : v[ACCUM_W-1:0];
        end
      end else begin
        pct_stopped = 1'b1;
      end
    end else begin
      if (mains_pos >= PERIOD) begin
        mains_pos = '0;
        err_a     = start_error(share_a);
        err_b     = start_error(share_b);
      end else begin
        mains_pos = mains_pos + 1'b1;
      end
      advance_gate(err_a, share_a, g.gate_a);
      advance_gate(err_b, share_b, g.gate_b);
      owed_gates.push_back(g);
    end
  endtask

  task automatic push_byte(input logic [BYTE_W-1:0] b);
    serial_word_t w;
    w.operation  = OP_BYTE;
    w.byte_value = b;
    pending_words.push_back(w);
  endtask

  task automatic push_tick(input logic [BYTE_W-1:0] b);
    serial_word_t w;
    w.operation  = OP_TICK;
    w.byte_value = b;
    pending_words.push_back(w);
  endtask

  task automatic push_text(input string s);
    for (int i = 0; i < s.len(); i++) push_byte(s[i]);
  endtask

  // monitor: predict on input words, check output words
  always @(posedge clk_i) begin : monitor
    gate_word_t g;
    if (rst_ni) begin
      in_taken  <= in_if.valid && in_if.ready;
      out_taken <= out_if.valid && out_if.ready;
      if (in_if.valid && in_if.ready) begin
        predict_word('{operation: in_if.operation, byte_value: in_if.byte_value});
      end
      if (out_if.valid && out_if.ready) begin
        gates_seen++;
        if (owed_gates.size() == 0) begin
          $display("%0t: unexpected gate word a=%0b b=%0b", $time,
                   out_if.gate_a, out_if.gate_b);
          fail_count++;
        end else begin
          g = owed_gates.pop_front();
          if (out_if.gate_a !== g.gate_a) begin
            $display("%0t: gate_a expected %0b got %0b", $time, g.gate_a, out_if.gate_a);
            fail_count++;
          end
          if (out_if.gate_b !== g.gate_b) begin
            $display("%0t: gate_b expected %0b got %0b", $time, g.gate_b, out_if.gate_b);
            fail_count++;
          end
        end
      end
    end else begin
      in_taken  <= 1'b0;
      out_taken <= 1'b0;
    end
  end

  // sender: next word after the current one is taken, with random gaps
  always @(negedge clk_i) begin : sender
    serial_word_t w;
    logic         next_valid;
    next_valid = in_if.valid;
    if (rst_ni && (!in_if.valid || in_taken)) begin
      if (send_wait > 0) begin
        send_wait--;
        next_valid = 1'b0;
      end else if (pending_words.size() > 0) begin
        w = pending_words.pop_front();
        next_valid = 1'b1;
        in_if.operation  <= w.operation;
        in_if.byte_value <= w.byte_value;
        if ($urandom_range(0, 29) == 0) send_calm = !send_calm;
        send_wait = send_calm ? 0 : $urandom_range(0, 10);
      end else begin
        next_valid = 1'b0;
      end
    end
    in_if.valid <= next_valid;
  end

  // receiver: random stall before each gate word, long hold when asked
  always @(negedge clk_i) begin : receiver
    if (rst_ni) begin
      if (out_taken) begin
        if ($urandom_range(0, 29) == 0) recv_calm = !recv_calm;
        recv_wait = recv_calm ? 0 : $urandom_range(0, 10);
      end
      if (recv_wait > 0) begin
        recv_wait--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= !hold_off;
      end
    end
  end

  // long receiver hold so the block backs up into its input
  initial begin : long_hold
    hold_off = 1'b0;
    while (gates_seen < 30) @(posedge clk_i);
    hold_off = 1'b1;
    repeat (150) @(posedge clk_i);
    hold_off = 1'b0;
  end

  // watchdog
  initial begin : watchdog
    #2000000;
    $display("Regression FAIL");
    $finish;
  end

  // stimulus and end of run
  initial begin : stimulus
    int pick;
    int ndig;
    fail_count       = 0;
    gates_seen       = 0;
    in_taken         = 1'b0;
    out_taken        = 1'b0;
    send_wait        = 0;
    recv_wait        = 0;
    send_calm        = 1'b0;
    recv_calm        = 1'b0;
    pct_accum        = '0;
    pct_stopped      = 1'b0;
    share_a          = '0;
    share_b          = '0;
    err_a            = '0;
    err_b            = '0;
    mains_pos        = '0;
    in_if.valid      = 1'b0;
    in_if.operation  = OP_BYTE;
    in_if.byte_value = '0;
    out_if.ready     = 1'b0;
    rst_ni           = 1'b0;

    // ticks before any newline: both fire once, then idle
    push_tick(8'h00);
    push_tick(8'hFF);
    // saturation at full scale
    push_text("999");
    push_byte(CHAR_NEWLINE);
    push_tick(8'h5A);
    push_tick(8'hA5);
    // zero percent
    push_text("0");
    push_byte(CHAR_NEWLINE);
    push_tick(8'h0F);
    // sign stops parsing
    push_text("-5");
    push_byte(CHAR_NEWLINE);
    push_tick(8'hF0);
    // space stops parsing, later digit ignored
    push_text("35 7");
    push_byte(CHAR_NEWLINE);
    push_tick(8'h33);
    // byte extremes as non-digits
    push_byte(8'h00);
    push_byte(8'hFF);
    push_byte(CHAR_NEWLINE);
    push_tick(8'hCC);

    // random: mostly percent strings followed by ticks
    while (pending_words.size() < 650) begin
      pick = $urandom_range(0, 9);
      if (pick < 7 || pick == 9) begin
        ndig = $urandom_range(1, 3);
        for (int i = 0; i < ndig; i++) begin
          if ($urandom_range(0, 7) == 0) push_byte(BYTE_W'($urandom_range(0, 255)));
          push_byte(CHAR_ZERO + BYTE_W'($urandom_range(0, 9)));
        end
        if (pick != 9) push_byte(CHAR_NEWLINE);
        repeat ($urandom_range(1, 24)) push_tick(BYTE_W'($urandom_range(0, 255)));
      end else if (pick == 7) begin
        repeat ($urandom_range(1, 4)) push_byte(BYTE_W'($urandom_range(0, 255)));
      end else begin
        repeat ($urandom_range(1, 12)) push_tick(BYTE_W'($urandom_range(0, 255)));
      end
    end

    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // drain: all words sent and all gate words back before the run ends
    while (pending_words.size() > 0 || in_if.valid || owed_gates.size() > 0)
      @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire
